/* hdl/cpa_pkg.sv */
// Shared types and constants for the contact pair aggregator.
package cpa_pkg;

    localparam int BODY_W      = 6;
    localparam int DIST_W      = 32;
    localparam int OUT_COUNT_W = 16;
    localparam int MASK_W      = 64;
    localparam int CFG_IDX_W   = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_BODIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_MASK  = 1'b1;

    // Input operation codes
    localparam logic OP_CONTACT = 1'b0;
    localparam logic OP_FLUSH   = 1'b1;

    // Filtered contact travelling down the cell chain
    typedef struct packed {
        logic                     valid;
        logic [BODY_W-1:0]        lo;
        logic [BODY_W-1:0]        hi;
        logic signed [DIST_W-1:0] dval;
    } cpa_token_t;

endpackage

/* hdl/cpa_if.sv */
// Handshake channel interfaces for contacts in and pair results out.
interface cpa_in_if;
    import cpa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic                     is_flex;
    logic [BODY_W-1:0]        body_a;
    logic [BODY_W-1:0]        body_b;
    logic signed [DIST_W-1:0] distance;

    modport source (output valid, op, is_flex, body_a, body_b, distance, input ready);
    modport sink   (input valid, op, is_flex, body_a, body_b, distance, output ready);
endinterface

interface cpa_out_if;
    import cpa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     pair_valid;
    logic [BODY_W-1:0]        low_body;
    logic [BODY_W-1:0]        high_body;
    logic [OUT_COUNT_W-1:0]   contact_count;
    logic signed [DIST_W-1:0] least_dist;
    logic                     overflowed;
    logic                     last;

    modport source (output valid, pair_valid, low_body, high_body, contact_count,
                    least_dist, overflowed, last, input ready);
    modport sink   (input valid, pair_valid, low_body, high_body, contact_count,
                    least_dist, overflowed, last, output ready);
endinterface

/* hdl/cpa_cell.sv */
// One table cell: holds a pair entry, folds in a passing contact, forwards the rest.
module cpa_cell #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               occupied,
    input  logic                               shift,
    input  cpa_pkg::cpa_token_t                tok_in,
    output cpa_pkg::cpa_token_t                tok_out,
    input  logic [cpa_pkg::BODY_W-1:0]         nbr_low,
    input  logic [cpa_pkg::BODY_W-1:0]         nbr_high,
    input  logic [COUNT_WIDTH-1:0]             nbr_count,
    input  logic signed [cpa_pkg::DIST_W-1:0]  nbr_min,
    output logic [cpa_pkg::BODY_W-1:0]         ent_low,
    output logic [cpa_pkg::BODY_W-1:0]         ent_high,
    output logic [COUNT_WIDTH-1:0]             ent_count,
    output logic signed [cpa_pkg::DIST_W-1:0]  ent_min,
    output logic                               inserted
);
    import cpa_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [BODY_W-1:0]        low_reg, low_next;
    logic [BODY_W-1:0]        high_reg, high_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic signed [DIST_W-1:0] min_reg, min_next;
    cpa_token_t               tok_reg, tok_next;
    logic                     match;
    logic                     take;

    // Match against the held entry; an empty cell takes the contact as a new entry
    assign match    = occupied && (low_reg == tok_in.lo) && (high_reg == tok_in.hi);
    assign take     = tok_in.valid && (match || !occupied);
    assign inserted = tok_in.valid && !occupied;

    // Entry update: flush shift, insert, or fold in
    always_comb
    begin
        low_next   = low_reg;
        high_next  = high_reg;
        count_next = count_reg;
        min_next   = min_reg;
        if (shift)
        begin
            low_next   = nbr_low;
            high_next  = nbr_high;
            count_next = nbr_count;
            min_next   = nbr_min;
        end
        else if (inserted)
        begin
            low_next   = tok_in.lo;
            high_next  = tok_in.hi;
            count_next = COUNT_WIDTH'(1);
            min_next   = tok_in.dval;
        end
        else if (tok_in.valid && match)
        begin
            if (count_reg != COUNT_MAX)
                count_next = count_reg + COUNT_WIDTH'(1);
            if ($signed(tok_in.dval) < min_reg)
                min_next = tok_in.dval;
        end
    end

    // Forward the contact unless consumed here
    always_comb
    begin
        tok_next       = tok_in;
        tok_next.valid = tok_in.valid && !take;
    end

    always_ff @(posedge clk)
    begin
        low_reg   <= low_next;
        high_reg  <= high_next;
        count_reg <= count_next;
        min_reg   <= min_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign tok_out   = tok_reg;
    assign ent_low   = low_reg;
    assign ent_high  = high_reg;
    assign ent_count = count_reg;
    assign ent_min   = min_reg;

endmodule

/* hdl/contact_pair_aggregator.sv */
// Contact pair aggregator: front end, cell chain, flush sequencer and output register.
//
// Usage:
//   contacts: one transaction per contact record (op 0) or end-of-step flush (op 1).
//   pairs:    result transactions of a flush, one per table entry in insertion
//             order, or a single empty marker; last marks the final one.
//   cfg:      cfg_wr_en writes all_bodies (index 0) or body_mask (index 1).
// Throughput: a contact is taken every cycle while no flush is under way. Each
//   contact walks the chain of MAX_PAIRS cells, one cell per cycle, so several
//   contacts are in flight at once; a contact that finds no match and no free
//   cell marks the overflow flag when it leaves the chain.
// Flush: the block waits until the chain is empty, then shifts entries out of
//   cell 0, one result per cycle while the output is not stalled. Input is
//   held off from the flush until its last result is loaded into the output
//   register. The table and overflow flag clear then.
// Stall: the output register holds a result until taken; the shift out waits.
// Reset: table empty, overflow flag clear, all_bodies = 1, body_mask = 0.
module contact_pair_aggregator #(
    parameter int MAX_PAIRS   = 32,
    parameter int MAX_BODIES  = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cpa_in_if.sink                            contacts,
    cpa_out_if.source                         pairs,
    input  logic                              cfg_wr_en,
    input  logic [cpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpa_pkg::MASK_W-1:0]        cfg_data
);
    import cpa_pkg::*;

    localparam int FILL_W = $clog2(MAX_PAIRS + 1);
    localparam int ID_W   = BODY_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic                     all_reg;
    logic [MASK_W-1:0]        mask_reg;
    cpa_token_t               stage_reg, stage_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic                     drop_reg, drop_next;

    cpa_token_t               tok_chain [MAX_PAIRS+1];
    logic [BODY_W-1:0]        low_chain [MAX_PAIRS+1];
    logic [BODY_W-1:0]        high_chain [MAX_PAIRS+1];
    logic [COUNT_WIDTH-1:0]   count_chain [MAX_PAIRS+1];
    logic signed [DIST_W-1:0] min_chain [MAX_PAIRS+1];
    logic [MAX_PAIRS-1:0]     ins_vec;
    logic [MAX_PAIRS-1:0]     tok_busy;
    logic                     busy;
    logic                     shift;

    logic                     in_take;
    logic [BODY_W-1:0]        lo_id, hi_id;
    logic                     lo_part, hi_part;
    logic                     out_free, emit_load, emit_last;
    logic [OUT_COUNT_W-1:0]   count_clamped;

    logic                     out_valid_reg, out_valid_next;
    logic                     pv_reg;
    logic [BODY_W-1:0]        low_out_reg;
    logic [BODY_W-1:0]        high_out_reg;
    logic [OUT_COUNT_W-1:0]   count_out_reg;
    logic signed [DIST_W-1:0] min_out_reg;
    logic                     ovf_out_reg;
    logic                     last_out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_reg  <= 1'b1;
            mask_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_ALL_BODIES)
                all_reg <= cfg_data[0];
            if (cfg_index == CFG_BODY_MASK)
                mask_reg <= cfg_data;
        end
    end

    // Front end: order ids and check participation
    assign contacts.ready = (state_reg == ST_IDLE);
    assign in_take = contacts.valid && contacts.ready;
    assign lo_id   = (contacts.body_a < contacts.body_b) ? contacts.body_a : contacts.body_b;
    assign hi_id   = (contacts.body_a < contacts.body_b) ? contacts.body_b : contacts.body_a;
    assign lo_part = ({1'b0, lo_id} < ID_W'(MAX_BODIES)) && (all_reg || mask_reg[lo_id]);
    assign hi_part = ({1'b0, hi_id} < ID_W'(MAX_BODIES)) && (all_reg || mask_reg[hi_id]);

    always_comb
    begin
        stage_next.valid = in_take && (contacts.op == OP_CONTACT) && !contacts.is_flex
                           && lo_part && hi_part;
        stage_next.lo    = lo_id;
        stage_next.hi    = hi_id;
        stage_next.dval  = contacts.distance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else
            stage_reg <= stage_next;
    end

    // Cell chain
    assign tok_chain[0]          = stage_reg;
    assign low_chain[MAX_PAIRS]   = '0;
    assign high_chain[MAX_PAIRS]  = '0;
    assign count_chain[MAX_PAIRS] = '0;
    assign min_chain[MAX_PAIRS]   = '0;

    for (genvar i = 0; i < MAX_PAIRS; i++)
    begin : g_cell
        logic occ;
        assign occ = (fill_reg > FILL_W'(i));
        assign tok_busy[i] = tok_chain[i+1].valid;

        cpa_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .occupied  (occ),
            .shift     (shift),
            .tok_in    (tok_chain[i]),
            .tok_out   (tok_chain[i+1]),
            .nbr_low   (low_chain[i+1]),
            .nbr_high  (high_chain[i+1]),
            .nbr_count (count_chain[i+1]),
            .nbr_min   (min_chain[i+1]),
            .ent_low   (low_chain[i]),
            .ent_high  (high_chain[i]),
            .ent_count (count_chain[i]),
            .ent_min   (min_chain[i]),
            .inserted  (ins_vec[i])
        );
    end

    assign busy = stage_reg.valid || (|tok_busy);

    // Saturated count narrowed to the output field
    if (COUNT_WIDTH > OUT_COUNT_W)
    begin : g_clamp
        assign count_clamped = (|count_chain[0][COUNT_WIDTH-1:OUT_COUNT_W]) ? '1
                               : count_chain[0][OUT_COUNT_W-1:0];
    end
    else
    begin : g_extend
        assign count_clamped = OUT_COUNT_W'(count_chain[0]);
    end

    // Flush sequencer
    assign out_free  = !out_valid_reg || pairs.ready;
    assign emit_load = (state_reg == ST_EMIT) && out_free;
    assign emit_last = (fill_reg <= FILL_W'(1));
    assign shift     = emit_load && (fill_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        drop_next  = drop_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (contacts.op == OP_FLUSH))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!busy)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_load && emit_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (|ins_vec)
            fill_next = fill_reg + FILL_W'(1);
        else if (shift)
            fill_next = fill_reg - FILL_W'(1);
        if (tok_chain[MAX_PAIRS].valid)
            drop_next = 1'b1;
        else if (emit_load && emit_last)
            drop_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_load)
            out_valid_next = 1'b1;
        else if (pairs.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            ovf_out_reg  <= drop_reg;
            last_out_reg <= emit_last;
            if (fill_reg == '0)
            begin
                pv_reg        <= 1'b0;
                low_out_reg   <= '0;
                high_out_reg  <= '0;
                count_out_reg <= '0;
                min_out_reg   <= '0;
            end
            else
            begin
                pv_reg        <= 1'b1;
                low_out_reg   <= low_chain[0];
                high_out_reg  <= high_chain[0];
                count_out_reg <= count_clamped;
                min_out_reg   <= min_chain[0];
            end
        end
    end

    assign pairs.valid         = out_valid_reg;
    assign pairs.pair_valid    = pv_reg;
    assign pairs.low_body      = low_out_reg;
    assign pairs.high_body     = high_out_reg;
    assign pairs.contact_count = count_out_reg;
    assign pairs.least_dist    = min_out_reg;
    assign pairs.overflowed    = ovf_out_reg;
    assign pairs.last          = last_out_reg;

`ifndef SYNTHESIS
    // Table never holds more entries than cells
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_PAIRS))
        else $error("fill count beyond table size");

    // Only the first free cell can take a new entry
    a_one_insert: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ins_vec))
        else $error("more than one cell inserted");

    // Shift out only once the chain has drained
    a_emit_idle_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !busy)
        else $error("contact in flight during flush");

    // Final result of a flush leaves the table and flag clear
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && emit_last) |=> (fill_reg == '0) && !drop_reg)
        else $error("table not cleared after flush");
`endif

endmodule

/* tb/contact_pair_aggregator_tb.sv */
// Self-checking testbench for the contact pair aggregator: random traffic, pair tally scoreboard.
module contact_pair_aggregator_tb;
    import cpa_pkg::*;

    localparam int MAX_PAIRS     = 32;
    localparam int MAX_BODIES    = 64;
    localparam int COUNT_WIDTH   = 16;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;
    localparam int GAP_MAX       = 18;
    localparam int SETTLE_CYCLES = MAX_PAIRS + 8;
    localparam int RANDOM_ITEMS  = 90;
    localparam int BURST_ITEMS   = 20;

    // One pair result as seen on the output channel
    typedef struct packed {
        logic                     pair_valid;
        logic [BODY_W-1:0]        low_body;
        logic [BODY_W-1:0]        high_body;
        logic [OUT_COUNT_W-1:0]   contact_count;
        logic signed [DIST_W-1:0] least_dist;
        logic                     overflowed;
        logic                     last;
    } pair_rec_t;

    // Pair table predictor and store of pending flush results
    class pair_tally;
        bit                     all_bodies;
        bit [MASK_W-1:0]        body_mask;
        bit [BODY_W-1:0]        ent_low   [MAX_PAIRS];
        bit [BODY_W-1:0]        ent_high  [MAX_PAIRS];
        longint unsigned        ent_count [MAX_PAIRS];
        bit signed [DIST_W-1:0] ent_min   [MAX_PAIRS];
        int                     used;
        bit                     dropped;
        pair_rec_t              expected_pairs[$];
        int                     failures;

        function new();
            all_bodies = 1'b1;
            body_mask  = '0;
            used       = 0;
            dropped    = 1'b0;
            failures   = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [MASK_W-1:0] data);
            if (idx == CFG_ALL_BODIES)
                all_bodies = data[0];
            else if (idx == CFG_BODY_MASK)
                body_mask = data;
        endfunction

        // ids past the body range never take part
        function bit takes_part(int unsigned id);
            if (id >= MAX_BODIES)
                return 1'b0;
            return all_bodies || body_mask[id];
        endfunction

        // Returns 1 when the transaction is not simply ignored
        function bit note_input(bit op, bit flex, bit [BODY_W-1:0] a, bit [BODY_W-1:0] b,
                                bit signed [DIST_W-1:0] dval);
            bit [BODY_W-1:0] lo;
            bit [BODY_W-1:0] hi;
            pair_rec_t       rec;
            if (op == OP_FLUSH)
            begin
                if (used == 0)
                begin
                    rec            = '0;
                    rec.overflowed = dropped;
                    rec.last       = 1'b1;
                    expected_pairs = {expected_pairs, rec};
                end
                for (int i = 0; i < used; i++)
                begin
                    rec.pair_valid    = 1'b1;
                    rec.low_body      = ent_low[i];
                    rec.high_body     = ent_high[i];
                    rec.contact_count = (ent_count[i] > 64'hFFFF) ? 16'hFFFF
                                                                  : OUT_COUNT_W'(ent_count[i]);
                    rec.least_dist    = ent_min[i];
                    rec.overflowed    = dropped;
                    rec.last          = (i == used - 1);
                    expected_pairs = {expected_pairs, rec};
                end
                used    = 0;
                dropped = 1'b0;
                return 1'b1;
            end
            if (flex)
                return 1'b0;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (!takes_part(lo) || !takes_part(hi))
                return 1'b0;
            for (int i = 0; i < used; i++)
            begin
                if (ent_low[i] == lo && ent_high[i] == hi)
                begin
                    if (ent_count[i] < COUNT_MAX)
                        ent_count[i]++;
                    if (dval < ent_min[i])
                        ent_min[i] = dval;
                    return 1'b1;
                end
            end
            // table full: contact lost, flag it
            if (used >= MAX_PAIRS)
            begin
                dropped = 1'b1;
                return 1'b1;
            end
            ent_low[used]   = lo;
            ent_high[used]  = hi;
            ent_count[used] = 1;
            ent_min[used]   = dval;
            used++;
            return 1'b1;
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        function void check_pair(pair_rec_t got);
            pair_rec_t want;
            if (expected_pairs.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pair result: valid=%0b lo=%0d hi=%0d count=%0d min=%0d",
                             got.pair_valid, got.low_body, got.high_body, got.contact_count,
                             got.least_dist);
                return;
            end
            want = expected_pairs.pop_front();
            if (got.pair_valid !== want.pair_valid || got.low_body !== want.low_body ||
                got.high_body !== want.high_body || got.contact_count !== want.contact_count ||
                got.least_dist !== want.least_dist || got.overflowed !== want.overflowed ||
                got.last !== want.last)
            begin
                failures++;
                if (failures <= 10)
                    $display({"pair mismatch: expected valid=%0b lo=%0d hi=%0d count=%0d ",
                              "min=%0d ovf=%0b last=%0b, got valid=%0b lo=%0d hi=%0d ",
                              "count=%0d min=%0d ovf=%0b last=%0b"},
                             want.pair_valid, want.low_body, want.high_body,
                             want.contact_count, want.least_dist, want.overflowed, want.last,
                             got.pair_valid, got.low_body, got.high_body, got.contact_count,
                             got.least_dist, got.overflowed, got.last);
            end
        endfunction

        function void close_out();
            if (expected_pairs.size() != 0)
            begin
                failures++;
                $display("%0d pair results never arrived", expected_pairs.size());
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0]    cfg_data;
    bit                   in_idle;
    bit                   out_idle;
    int                   taken;
    pair_tally            tally;

    cpa_in_if  contacts_if();
    cpa_out_if pairs_if();

    contact_pair_aggregator #(
        .MAX_PAIRS   (MAX_PAIRS),
        .MAX_BODIES  (MAX_BODIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .contacts  (contacts_if),
        .pairs     (pairs_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run limit
    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Send one input transaction; valid stays high afterwards for back-to-back items
    task automatic send(input bit op, input bit flex, input bit [BODY_W-1:0] a,
                        input bit [BODY_W-1:0] b, input bit signed [DIST_W-1:0] dval);
        int gap;
        gap = in_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap != 0)
        begin
            contacts_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        contacts_if.op       = op;
        contacts_if.is_flex  = flex;
        contacts_if.body_a   = a;
        contacts_if.body_b   = b;
        contacts_if.distance = dval;
        contacts_if.valid    = 1'b1;
        do @(posedge clk); while (contacts_if.ready !== 1'b1);
        void'(tally.note_input(op, flex, a, b, dval));
        taken++;
        @(negedge clk);
    endtask

    task automatic flush();
        send(OP_FLUSH, 1'($urandom), 6'($urandom), 6'($urandom), $urandom);
    endtask

    // Hold input until all flush results are in, then let the cell chain empty
    task automatic settle();
        contacts_if.valid = 1'b0;
        while (tally.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input bit [CFG_IDX_W-1:0] idx, input bit [MASK_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        tally.write_reg(idx, data);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input bit all, input bit [MASK_W-1:0] mask);
        write_cfg(CFG_ALL_BODIES, MASK_W'(all));
        write_cfg(CFG_BODY_MASK, mask);
    endtask

    function automatic bit signed [DIST_W-1:0] pick_dist();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stalls, check each accepted transaction
    initial
    begin
        int        stall;
        pair_rec_t got;
        pairs_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = out_idle ? $urandom_range(0, GAP_MAX) : 0;
            if (stall != 0)
            begin
                pairs_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            pairs_if.ready = 1'b1;
            do @(posedge clk); while (pairs_if.valid !== 1'b1);
            got.pair_valid    = pairs_if.pair_valid;
            got.low_body      = pairs_if.low_body;
            got.high_body     = pairs_if.high_body;
            got.contact_count = pairs_if.contact_count;
            got.least_dist    = pairs_if.least_dist;
            got.overflowed    = pairs_if.overflowed;
            got.last          = pairs_if.last;
            tally.check_pair(got);
            @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin
        bit [BODY_W-1:0] pool [16];
        bit [MASK_W-1:0] mask;
        bit              crowd;
        int              n;
        int              phase;

        tally                = new();
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = CFG_ALL_BODIES;
        cfg_data             = '0;
        contacts_if.valid    = 1'b0;
        contacts_if.op       = OP_CONTACT;
        contacts_if.is_flex  = 1'b0;
        contacts_if.body_a   = '0;
        contacts_if.body_b   = '0;
        contacts_if.distance = '0;
        in_idle              = 1'b1;
        out_idle             = 1'b1;
        taken                = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: empty marker, flex skip, id extremes, reversed pair, self pair
        flush();
        send(OP_CONTACT, 1'b1, 6'd1, 6'd2, 32'sd5);
        send(OP_CONTACT, 1'b0, 6'd63, 6'd0, 32'sh7FFF_FFFF);
        send(OP_CONTACT, 1'b0, 6'd0, 6'd63, 32'sh8000_0000);
        send(OP_CONTACT, 1'b0, 6'd5, 6'd5, 32'sd0);
        send(OP_CONTACT, 1'b0, 6'd63, 6'd0, 32'sd0);
        send(OP_FLUSH, 1'b0, 6'd63, 6'd63, 32'sh7FFF_FFFF);
        settle();

        // Mask with only the end bodies
        set_config(1'b0, 64'h8000_0000_0000_0001);
        send(OP_CONTACT, 1'b0, 6'd0, 6'd63, 32'sd100);
        send(OP_CONTACT, 1'b0, 6'd63, 6'd1, 32'sd100);
        send(OP_CONTACT, 1'b0, 6'd2, 6'd0, 32'sd100);
        send(OP_CONTACT, 1'b0, 6'd63, 6'd63, -32'sd7);
        flush();
        settle();

        // Empty mask: everything filtered
        set_config(1'b0, 64'h0);
        send(OP_CONTACT, 1'b0, 6'd0, 6'd63, 32'sd1);
        flush();
        settle();

        // Full mask
        set_config(1'b0, {MASK_W{1'b1}});
        send(OP_CONTACT, 1'b0, 6'd17, 6'd42, -32'sd3);
        send(OP_CONTACT, 1'b0, 6'd42, 6'd17, 32'sd9);
        flush();
        settle();

        // Back to reset values
        set_config(1'b1, 64'h0);
        send(OP_CONTACT, 1'b0, 6'd30, 6'd31, pick_dist());
        flush();
        settle();

        // Back-to-back run on one pair
        in_idle = 1'b0;
        repeat (BURST_ITEMS) send(OP_CONTACT, 1'b0, 6'd9, 6'd12, pick_dist());
        flush();
        settle();

        // Random phases: mostly live pairs from a small pool, some noise
        taken = 0;
        phase = 0;
        while (taken < RANDOM_ITEMS)
        begin
            in_idle  = $urandom_range(0, 3) != 0;
            out_idle = $urandom_range(0, 3) != 0;
            crowd    = (phase == 0) || ($urandom_range(0, 4) == 0);
            foreach (pool[k])
                pool[k] = BODY_W'($urandom_range(0, 63));
            mask = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0)
                foreach (pool[k])
                    mask[pool[k]] = 1'b1;
            set_config(crowd ? 1'b1 : 1'($urandom), mask);
            n = crowd ? $urandom_range(40, 56) : $urandom_range(2, 16);
            repeat (n)
            begin
                case ($urandom_range(0, 19))
                    0, 1: send(OP_CONTACT, 1'b1, 6'($urandom), 6'($urandom), $urandom);
                    2, 3: send(OP_CONTACT, 1'b0, 6'($urandom), 6'($urandom), pick_dist());
                    4:    flush();
                    default:
                        send(OP_CONTACT, 1'b0, pool[$urandom_range(0, crowd ? 15 : 3)],
                             pool[$urandom_range(0, crowd ? 15 : 3)], pick_dist());
                endcase
            end
            flush();
            settle();
            phase++;
        end

        tally.close_out();
        if (tally.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hdl/cpa_pkg.sv
hdl/cpa_if.sv
hdl/cpa_cell.sv
hdl/contact_pair_aggregator.sv
tb/contact_pair_aggregator_tb.sv
